### src/nrle_pkg.sv
// Shared types, constants and controller codes for the nibble RLE tile decoder.
package nrle_pkg;

    localparam int ROW_TILES_DEF = 7;
    localparam logic [3:0] ESCAPE_RESET = 4'hF;

    typedef struct packed {
        logic [3:0] nibble;
        logic       room_start;
    } in_item_t;

    typedef struct packed {
        logic [3:0] tile_id;
        logic [3:0] tile_col;
        logic [7:0] tile_row;
        logic       run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_PLAIN,
        ST_COUNT,
        ST_TILE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic clear_pos;
        logic load_count;
        logic emit_plain;
        logic start_run;
        logic emit_run;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic nib_is_esc;
        logic count_zero;
        logic count_one;
        logic remain_last;
    } status_t;

endpackage

### src/nrle_ctrl.sv
// Decode controller: tracks the stream phase and sequences run emission.
module nrle_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             room_start,
    output logic             in_ready,
    input  nrle_pkg::status_t status,
    output nrle_pkg::cmd_t    cmd
);
    import nrle_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t eff_state;
    logic   accept;

    assign in_ready  = (state_reg != ST_RUN) && status.out_free;
    assign accept    = in_valid && in_ready;
    assign eff_state = room_start ? ST_PLAIN : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PLAIN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (state_reg == ST_RUN)
        begin
            if (status.out_free && status.remain_last)
            begin
                state_next = ST_PLAIN;
            end
        end
        else if (accept)
        begin
            case (eff_state)
                ST_PLAIN: state_next = status.nib_is_esc ? ST_COUNT : ST_PLAIN;
                ST_COUNT: state_next = ST_TILE;
                ST_TILE:
                begin
                    if (status.count_zero || status.count_one)
                    begin
                        state_next = ST_PLAIN;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
                default: state_next = ST_PLAIN;
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        if (state_reg == ST_RUN)
        begin
            cmd.emit_run = status.out_free;
        end
        else if (accept)
        begin
            cmd.clear_pos = room_start;
            case (eff_state)
                ST_COUNT: cmd.load_count = 1'b1;
                ST_TILE:  cmd.start_run  = !status.count_zero;
                default:  cmd.emit_plain = !status.nib_is_esc;
            endcase
        end
    end

endmodule

### src/nrle_dpath.sv
// Datapath: escape register, run count, tile position and output register.
module nrle_dpath #(
    parameter int ROW_TILES = nrle_pkg::ROW_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  nrle_pkg::in_item_t  in_data,
    input  logic               out_ready,
    output logic               out_valid,
    output nrle_pkg::out_item_t out_data,
    input  nrle_pkg::cmd_t      cmd,
    output nrle_pkg::status_t   status
);
    import nrle_pkg::*;

    localparam logic [3:0] COL_LAST = 4'(ROW_TILES - 1);

    logic [3:0] esc_reg;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [3:0] tile_reg;
    logic [3:0] tile_next;
    logic [3:0] remain_reg;
    logic [3:0] remain_next;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [3:0] col_reg;
    logic [3:0] col_next;
    logic [7:0] row_reg;
    logic [7:0] row_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_data_reg;
    out_item_t  out_data_next;

    logic [7:0] pos_cur;
    logic [3:0] col_cur;
    logic [7:0] row_cur;
    logic       emit;

    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.nib_is_esc  = (in_data.nibble == esc_reg);
    assign status.count_zero  = (count_reg == 4'd0);
    assign status.count_one   = (count_reg == 4'd1);
    assign status.remain_last = (remain_reg == 4'd1);

    assign emit    = cmd.emit_plain || cmd.start_run || cmd.emit_run;
    assign pos_cur = cmd.clear_pos ? 8'd0 : pos_reg;
    assign col_cur = cmd.clear_pos ? 4'd0 : col_reg;
    assign row_cur = cmd.clear_pos ? 8'd0 : row_reg;

    always_comb
    begin
        pos_next = pos_cur;
        col_next = col_cur;
        row_next = row_cur;
        if (emit)
        begin
            pos_next = pos_cur + 8'd1;
            if (pos_cur == 8'hFF)
            begin
                col_next = 4'd0;
                row_next = 8'd0;
            end
            else if (col_cur == COL_LAST)
            begin
                col_next = 4'd0;
                row_next = row_cur + 8'd1;
            end
            else
            begin
                col_next = col_cur + 4'd1;
            end
        end
    end

    always_comb
    begin
        count_next  = cmd.load_count ? in_data.nibble : count_reg;
        tile_next   = cmd.start_run ? in_data.nibble : tile_reg;
        remain_next = remain_reg;
        if (cmd.start_run)
        begin
            remain_next = count_reg - 4'd1;
        end
        else if (cmd.emit_run)
        begin
            remain_next = remain_reg - 4'd1;
        end
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (emit)
        begin
            out_valid_next         = 1'b1;
            out_data_next.tile_id  = cmd.emit_run ? tile_reg : in_data.nibble;
            out_data_next.tile_col = col_cur;
            out_data_next.tile_row = row_cur;
            if (cmd.emit_plain)
            begin
                out_data_next.run_last = 1'b1;
            end
            else if (cmd.start_run)
            begin
                out_data_next.run_last = status.count_one;
            end
            else
            begin
                out_data_next.run_last = status.remain_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= ESCAPE_RESET;
            count_reg     <= 4'd0;
            remain_reg    <= 4'd0;
            pos_reg       <= 8'd0;
            col_reg       <= 4'd0;
            row_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                esc_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tile_reg     <= tile_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/nibble_rle_tile_decoder_top.sv
// Top level of the nibble RLE tile decoder.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_item_t  {nibble, room_start}
//  out       output     out_valid / out_ready  out_item_t {tile_id, tile_col, tile_row, run_last}
//  cfg       input      cfg_we                 cfg_wdata  escape code
//
// One nibble is taken per cycle while in_ready is high; a plain nibble's tile shows on the next cycle.
// A run of N tiles holds in_ready low after its tile nibble until its last tile is emitted,
// emitting one tile per cycle from the single output register while the output is not stalled.
// Reset is asynchronous and brings back escape code 15 and position zero.
// A stalled output blocks new transfers until the output register frees.
module nibble_rle_tile_decoder_top #(
    parameter int ROW_TILES = nrle_pkg::ROW_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nrle_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output nrle_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata
);
    import nrle_pkg::*;

    cmd_t    cmd;
    status_t status;

    nrle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .room_start (in_data.room_start),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    nrle_dpath #(
        .ROW_TILES (ROW_TILES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### src/nrle_checker.sv
// Port-level checker for the nibble RLE tile decoder, bound to the top level.
module nrle_checker #(
    parameter int ROW_TILES = nrle_pkg::ROW_TILES_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input nrle_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input nrle_pkg::out_item_t out_data,
    input logic               cfg_we,
    input logic [3:0]         cfg_wdata
);
    import nrle_pkg::*;

    localparam logic [4:0] COL_LIMIT = 5'(ROW_TILES);

    logic [3:0] esc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= ESCAPE_RESET;
        end
        else if (cfg_we)
        begin
            esc_reg <= cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_mid_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.run_last |-> !in_ready)
        else $error("input taken in the middle of a run");

    a_room_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.room_start && (in_data.nibble != esc_reg)
        |=> out_valid && (out_data.tile_col == 4'd0) && (out_data.tile_row == 8'd0)
            && out_data.run_last)
        else $error("room start tile not at origin");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, out_data.tile_col} < COL_LIMIT)
        else $error("column beyond row width");

endmodule

bind nibble_rle_tile_decoder_top nrle_checker #(
    .ROW_TILES (ROW_TILES)
) u_nrle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the nibble RLE tile decoder: directed and randomized room streams checked against a predictor.
module tb;
    import nrle_pkg::*;

    localparam int TPR = ROW_TILES_DEF;
    localparam int MAX_GAP = 14;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 24;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;

    nibble_rle_tile_decoder_top #(
        .ROW_TILES(TPR)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder mirror
    logic [3:0] esc_code = ESCAPE_RESET;
    state_t     dec_phase = ST_PLAIN;
    logic [3:0] run_count = 4'd0;
    logic [7:0] tile_pos = 8'd0;
    out_item_t  tile_q[$];

    in_item_t   nibble_q[$];
    int         nibbles_queued = 0;
    int         nibbles_taken = 0;
    int         tiles_checked = 0;
    int         pos_wraps = 0;
    int         errors = 0;

    logic       in_fire = 1'b0;
    logic       out_fire = 1'b0;
    logic       in_idle_en = 1'b1;
    logic       out_idle_en = 1'b1;
    logic       want_hold = 1'b0;
    logic       did_hold = 1'b0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         hold_left = 0;
    logic       nxt_valid;
    in_item_t   nxt_item;

    task automatic push_tile(input logic [3:0] id, input logic last);
        out_item_t t;
        t.tile_id = id;
        t.tile_col = 4'(int'(tile_pos) % TPR);
        t.tile_row = 8'(int'(tile_pos) / TPR);
        t.run_last = last;
        tile_q.push_back(t);
        if (tile_pos == 8'hFF)
            pos_wraps++;
        tile_pos = tile_pos + 8'd1;
    endtask

    task automatic decode_nibble(input in_item_t it);
        if (it.room_start)
        begin
            dec_phase = ST_PLAIN;
            run_count = 4'd0;
            tile_pos = 8'd0;
        end
        case (dec_phase)
            ST_COUNT:
            begin
                run_count = it.nibble;
                dec_phase = ST_TILE;
            end
            ST_TILE:
            begin
                for (int c = 1; c <= int'(run_count); c++)
                    push_tile(it.nibble, c == int'(run_count));
                run_count = 4'd0;
                dec_phase = ST_PLAIN;
            end
            default:
            begin
                dec_phase = ST_PLAIN;
                if (it.nibble == esc_code)
                    dec_phase = ST_COUNT;
                else
                    push_tile(it.nibble, 1'b1);
            end
        endcase
    endtask

    task automatic check_tile(input out_item_t got);
        out_item_t want;
        if (tile_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected tile id=%h col=%0d row=%0d last=%b", $time,
                     got.tile_id, got.tile_col, got.tile_row, got.run_last);
        end
        else
        begin
            want = tile_q.pop_front();
            tiles_checked++;
            if (got !== want)
            begin
                errors++;
                $display("%0t: tile mismatch expected id=%h col=%0d row=%0d last=%b",
                         $time, want.tile_id, want.tile_col, want.tile_row, want.run_last);
                $display("%0t:                  actual id=%h col=%0d row=%0d last=%b",
                         $time, got.tile_id, got.tile_col, got.tile_row, got.run_last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (in_fire)
        begin
            nibbles_taken++;
            decode_nibble(in_data);
        end
        if (out_fire)
            check_tile(out_data);
    end

    // sender
    always @(negedge clk)
    begin
        nxt_valid = in_valid;
        nxt_item = in_data;
        if (in_fire)
        begin
            nxt_valid = 1'b0;
            in_gap = in_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (rst_n && !nxt_valid)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (nibble_q.size() > 0)
            begin
                nxt_item = nibble_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        in_valid <= nxt_valid;
        in_data <= nxt_item;
    end

    // receiver
    always @(negedge clk)
    begin
        if (out_fire)
        begin
            out_gap = out_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (want_hold && !did_hold)
            begin
                did_hold = 1'b1;
                hold_left = LONG_HOLD;
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic push_item(input logic [3:0] nib, input logic start);
        in_item_t it;
        it.nibble = nib;
        it.room_start = start;
        nibble_q.push_back(it);
        nibbles_queued++;
    endtask

    task automatic wait_idle();
        while (nibbles_taken != nibbles_queued || tile_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_escape(input logic [3:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        esc_code = value;
    endtask

    function automatic logic [3:0] plain_nibble();
        logic [3:0] n;
        n = 4'($urandom_range(0, 15));
        if (n == esc_code)
            n = n + 4'd1;
        return n;
    endfunction

    task automatic gen_rooms(input int n_items);
        int   stop_at;
        int   room_left;
        logic start;
        stop_at = nibbles_queued + n_items;
        room_left = 0;
        start = 1'b1;
        while (nibbles_queued < stop_at)
        begin
            case ($urandom_range(0, 9))
                0: push_item(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                1:
                begin
                    // broken run: drop it with a new room
                    push_item(esc_code, start);
                    if ($urandom_range(0, 1))
                        push_item(4'($urandom_range(0, 15)), 1'b0);
                    start = 1'b1;
                    room_left = 0;
                end
                default:
                begin
                    if (room_left == 0)
                    begin
                        room_left = ($urandom_range(0, 3) == 0) ? $urandom_range(90, 130)
                                                                : $urandom_range(1, 40);
                        start = 1'b1;
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        push_item(esc_code, start);
                        push_item(4'($urandom_range(0, 15)), 1'b0);
                        push_item(4'($urandom_range(0, 15)), 1'b0);
                    end
                    else
                        push_item(plain_nibble(), start);
                    start = 1'b0;
                    room_left--;
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_item(4'd0, 1'b1);
        push_item(4'd14, 1'b0);
        push_item(4'd15, 1'b0);
        push_item(4'd0, 1'b0);
        push_item(4'd5, 1'b0);
        push_item(4'd15, 1'b0);
        push_item(4'd15, 1'b0);
        push_item(4'd15, 1'b0);
        push_item(4'd15, 1'b0);
        push_item(4'd1, 1'b0);
        push_item(4'd7, 1'b0);
        push_item(4'd15, 1'b0);
        push_item(4'd3, 1'b0);
        push_item(4'd9, 1'b1);
        push_item(4'd15, 1'b0);
        push_item(4'd10, 1'b1);
        push_item(4'd15, 1'b1);
        push_item(4'd2, 1'b0);
        push_item(4'd6, 1'b0);
        push_item(4'd8, 1'b0);
        push_item(4'd3, 1'b0);
        push_item(4'd12, 1'b0);

        write_escape(4'd0);
        want_hold = 1'b1;
        gen_rooms(135);

        write_escape(4'($urandom_range(1, 14)));
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        gen_rooms(135);

        write_escape(4'd15);
        out_idle_en = 1'b1;
        gen_rooms(135);

        wait_idle();
        $display("Decoded %0d nibbles into %0d checked tiles over four escape settings,",
                 nibbles_taken, tiles_checked);
        $display("with %0d tile position wraps and a %0d-cycle output stall.",
                 pos_wraps, LONG_HOLD);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d tiles still expected", tile_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
